// File: src/dteq_pkg.sv
// Package for the delta-time event queue: entry and command types shared by
// the cell and the top level, and operation and error codes for the top level.
`timescale 1ns / 1ps
`default_nettype none

package dteq_pkg;

  localparam int TIME_W  = 16;
  localparam int TAG_W   = 8;
  localparam int COUNT_W = 5;

  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [1:0] FUNC_POP     = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] time_val;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              upd;
    logic              ins;
    logic              adv;
    logic              pop;
    logic [TIME_W-1:0] ins_time;
    logic [TAG_W-1:0]  ins_tag;
    logic [TIME_W-1:0] amount;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/dteq_cell.sv
// One storage cell of the sorted event chain: holds a single (time, tag)
// entry and trades it with its neighbors. Depends on dteq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dteq_cell
  import dteq_pkg::*;
(
  input  wire logic   clk,
  input  wire cmd_t   cmd,
  input  wire logic   occ,
  input  wire logic   smaller_left,
  input  wire entry_t entry_left,
  input  wire entry_t entry_right,
  output logic        smaller,
  output entry_t      entry,
  output entry_t      entry_next
);

  assign smaller = occ && (entry.time_val < cmd.ins_time);

  always_comb begin
    entry_next = entry;
    if (cmd.ins) begin
      // Cells holding a smaller time keep it; the first cell that does not
      // takes the new entry, and every cell behind it shifts one place back.
      if (!smaller) begin
        if (smaller_left) begin
          entry_next.time_val = cmd.ins_time;
          entry_next.tag      = cmd.ins_tag;
        end else begin
          entry_next = entry_left;
        end
      end
    end else if (cmd.adv) begin
      entry_next.time_val = (entry.time_val > cmd.amount) ?
                            (entry.time_val - cmd.amount) : '0;
    end else if (cmd.pop) begin
      entry_next = entry_right;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

// File: src/delta_time_event_queue.sv
// Delta-time event queue: a chain of cells that keeps (time, tag) entries
// in ascending time order. Depends on dteq_pkg and dteq_cell.
//
// Usage: each transfer on the slave stream carries one operation in s_tuser
// (insert, advance, pop) with its operands in s_tdata. Insert places the new
// entry behind every stored entry with a strictly smaller time. Advance
// subtracts an amount from every stored time, clamped at zero. Pop removes
// the head. Every operation yields exactly one result transfer on the master
// stream with the popped entry, the new head, the entry count and an error
// code (insert when full and pop when empty change nothing).
// The result is registered and appears in the cycle after the input transfer.
// Throughput is one operation per cycle unless the receiver stalls: all cells
// compare, shift or subtract in the same cycle, and the result sits in one
// output register. While the receiver stalls a held result, s_tready drops;
// it returns in the cycle the result is taken. Synchronous reset empties the
// queue and clears the output valid; entry contents are left as they are and
// never read until written.
`timescale 1ns / 1ps
`default_nettype none

module delta_time_event_queue
  import dteq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata fields from bit 0: event_time[15:0], event_tag[23:16],
  // advance_amount[39:24]
  input  wire logic [39:0] s_tdata,
  // s_tuser fields from bit 0: func[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata fields from bit 0: popped_time[15:0], popped_tag[23:16],
  // head_time[39:24], head_tag[47:40], head_valid[48], entry_count[53:49],
  // error_code[55:54]
  output logic [55:0]      m_tdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  logic [1:0]       err;
  cmd_t             cmd;

  logic   [QUEUE_DEPTH-1:0] occ;
  logic   [QUEUE_DEPTH:0]   smaller_chain;
  entry_t                   cell_entry [QUEUE_DEPTH];
  entry_t                   cell_next  [QUEUE_DEPTH];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    cmd          = '0;
    cmd.ins_time = s_tdata[15:0];
    cmd.ins_tag  = s_tdata[23:16];
    cmd.amount   = s_tdata[39:24];
    err          = ERR_OK;
    count_next   = count;
    case (s_tuser)
      FUNC_INSERT: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          cmd.ins    = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      FUNC_ADVANCE: begin
        cmd.adv = 1'b1;
      end
      FUNC_POP: begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          cmd.pop    = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    cmd.upd = accept && (cmd.ins || cmd.adv || cmd.pop);
  end

  // The head cell sees every entry ahead of it as smaller, so an insert with
  // no smaller stored time lands at the head.
  assign smaller_chain[0] = 1'b1;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_in;
    entry_t right_in;

    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_mid
      assign left_in = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_body
      assign right_in = cell_entry[i+1];
    end

    dteq_cell u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .occ          (occ[i]),
      .smaller_left (smaller_chain[i]),
      .entry_left   (left_in),
      .entry_right  (right_in),
      .smaller      (smaller_chain[i+1]),
      .entry        (cell_entry[i]),
      .entry_next   (cell_next[i])
    );
  end

  logic [CNT_W+COUNT_W-1:0] count_ext;
  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata[15:0]  <= cmd.pop ? cell_entry[0].time_val : '0;
      m_tdata[23:16] <= cmd.pop ? cell_entry[0].tag : '0;
      m_tdata[39:24] <= (count_next != '0) ? cell_next[0].time_val : '0;
      m_tdata[47:40] <= (count_next != '0) ? cell_next[0].tag : '0;
      m_tdata[48]    <= (count_next != '0);
      m_tdata[53:49] <= count_ext[COUNT_W-1:0];
      m_tdata[55:54] <= err;
    end
  end

  logic [CNT_W+COUNT_W-1:0] count_now_ext;
  assign count_now_ext = {{COUNT_W{1'b0}}, count};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == FUNC_INSERT && full) |=>
      (m_tvalid && m_tdata[55:54] == ERR_FULL && full))
    else $error("insert on a full queue not flagged or changed the count");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == FUNC_POP && empty) |=>
      (m_tvalid && m_tdata[55:54] == ERR_EMPTY && !m_tdata[48] && empty))
    else $error("pop on an empty queue not flagged");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[53:49] == count_now_ext[COUNT_W-1:0]))
    else $error("reported count differs from stored count");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[48] == !empty))
    else $error("head valid flag differs from queue occupancy");

endmodule

`default_nettype wire
